// ----- design/ccs_pkg.sv -----
`default_nettype none

package ccs_pkg;

    // Splice counting
    localparam int MAX_SPLICES = 7;
    localparam int SPL_W       = $clog2(MAX_SPLICES + 1);

    // Queue between classifier and expander
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Result slots per request bundle
    localparam int SLOTS  = 4;
    localparam int SLOT_W = $clog2(SLOTS);

    // Characters of interest
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef enum logic [2:0] {
        M_NORMAL = 3'd0,
        M_LINE   = 3'd1,
        M_BLOCK  = 3'd2,
        M_STAR   = 3'd3,
        M_QUOTE  = 3'd4,
        M_ESC    = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_COMMENT = 2'd1,
        ERR_LITERAL = 2'd2
    } t_err;

    // One kept character with its splices, or the end-of-stream marker
    typedef struct packed {
        logic             valid;
        logic             final_mark;
        logic [7:0]       ch;
        logic [SPL_W-1:0] spl;
        t_err             err;
    } t_slot;

    typedef t_slot [SLOTS-1:0] t_bundle;

    function automatic t_slot mk_slot(logic [7:0] ch, logic [SPL_W-1:0] spl);
        t_slot s;
        s.valid      = 1'b1;
        s.final_mark = 1'b0;
        s.ch         = ch;
        s.spl        = spl;
        s.err        = ERR_NONE;
        return s;
    endfunction

    function automatic t_slot no_slot();
        t_slot s;
        s.valid      = 1'b0;
        s.final_mark = 1'b0;
        s.ch         = '0;
        s.spl        = '0;
        s.err        = ERR_NONE;
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- design/ccs_front.sv -----
`default_nettype none

module ccs_front import ccs_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_end_of_input,
    input  wire logic       i_full,
    output logic            o_stall,
    output logic            o_push,
    output t_bundle         o_bundle
);

    typedef struct packed {
        t_mode            mode;
        logic             quote_kind;
        logic             held_slash;
        logic [SPL_W-1:0] held_slash_spl;
    } t_sstate;

    typedef struct packed {
        t_sstate st;
        t_slot   a;
        t_slot   b;
    } t_strip_res;

    // Classify one logical character; a carries a released slash, b the character
    function automatic t_strip_res strip(t_sstate st, logic [7:0] c, logic [SPL_W-1:0] s);
        t_strip_res r;
        logic       skip;
        r.st = st;
        r.a  = no_slot();
        r.b  = no_slot();
        skip = 1'b0;
        case (st.mode)
            M_LINE: begin
                if (c == CH_NL) begin
                    r.b       = mk_slot(c, s);
                    r.st.mode = M_NORMAL;
                end
            end
            M_BLOCK: begin
                if (c == CH_STAR) begin
                    r.st.mode = M_STAR;
                end
            end
            M_STAR: begin
                if (c == CH_SLASH) begin
                    r.st.mode = M_NORMAL;
                end else if (c != CH_STAR) begin
                    r.st.mode = M_BLOCK;
                end
            end
            M_QUOTE: begin
                r.b = mk_slot(c, s);
                if (c == CH_BSLASH) begin
                    r.st.mode = M_ESC;
                end else if (c == (st.quote_kind ? CH_DQUOTE : CH_SQUOTE)) begin
                    r.st.mode = M_NORMAL;
                end
            end
            M_ESC: begin
                r.b       = mk_slot(c, s);
                r.st.mode = M_QUOTE;
            end
            default: begin
                r.st.mode = M_NORMAL;
                if (st.held_slash) begin
                    r.st.held_slash = 1'b0;
                    if (c == CH_SLASH) begin
                        r.st.mode = M_LINE;
                        skip      = 1'b1;
                    end else if (c == CH_STAR) begin
                        r.b       = mk_slot(CH_SPACE, '0);
                        r.st.mode = M_BLOCK;
                        skip      = 1'b1;
                    end else begin
                        r.a = mk_slot(CH_SLASH, st.held_slash_spl);
                    end
                end
                if (!skip) begin
                    if (c == CH_SLASH) begin
                        r.st.held_slash     = 1'b1;
                        r.st.held_slash_spl = s;
                    end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
                        r.b             = mk_slot(c, s);
                        r.st.quote_kind = (c == CH_DQUOTE);
                        r.st.mode       = M_QUOTE;
                    end else begin
                        r.b = mk_slot(c, s);
                    end
                end
            end
        endcase
        return r;
    endfunction

    t_sstate          r_st, n_st;
    logic             r_held_bs, n_held_bs;
    logic [SPL_W-1:0] r_held_bs_spl, n_held_bs_spl;
    logic [SPL_W-1:0] r_pending, n_pending;
    logic             r_finished, n_finished;

    logic             accept;
    t_bundle          bundle;
    t_strip_res       res1, res2;
    logic [SPL_W:0]   spl_inc;
    t_sstate          st1;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    // Work out the next state and the results of one request
    always_comb begin
        n_st          = r_st;
        n_held_bs     = r_held_bs;
        n_held_bs_spl = r_held_bs_spl;
        n_pending     = r_pending;
        n_finished    = r_finished;
        bundle        = {SLOTS{no_slot()}};
        res1          = strip(r_st, CH_BSLASH, r_held_bs_spl);
        st1           = r_held_bs ? res1.st : r_st;
        res2          = strip(st1, i_in_byte, r_pending);
        spl_inc       = {1'b0, r_held_bs_spl} + 1'b1;
        if (r_finished) begin
            // drop everything after end of stream
        end else if (i_end_of_input) begin
            if (r_held_bs) begin
                bundle[0] = res1.a;
                bundle[1] = res1.b;
            end
            n_held_bs = 1'b0;
            n_pending = '0;
            n_st      = st1;
            bundle[3] = no_slot();
            bundle[3].valid      = 1'b1;
            bundle[3].final_mark = 1'b1;
            if (st1.mode == M_BLOCK || st1.mode == M_STAR) begin
                bundle[3].err = ERR_COMMENT;
            end else if (st1.mode == M_QUOTE || st1.mode == M_ESC) begin
                bundle[3].err = ERR_LITERAL;
            end else if (st1.mode != M_LINE && st1.held_slash) begin
                bundle[2] = mk_slot(CH_SLASH, st1.held_slash_spl);
            end
            n_st.held_slash = 1'b0;
            n_finished      = 1'b1;
        end else if (r_held_bs && i_in_byte == CH_NL) begin
            // splice: count it against the next character
            n_held_bs = 1'b0;
            n_pending = (spl_inc > (SPL_W+1)'(MAX_SPLICES)) ? SPL_W'(MAX_SPLICES)
                                                            : spl_inc[SPL_W-1:0];
        end else begin
            if (r_held_bs) begin
                bundle[0] = res1.a;
                bundle[1] = res1.b;
            end
            n_held_bs = 1'b0;
            n_st      = st1;
            if (i_in_byte == CH_BSLASH) begin
                n_held_bs     = 1'b1;
                n_held_bs_spl = r_pending;
            end else begin
                bundle[2] = res2.a;
                bundle[3] = res2.b;
                n_st      = res2.st;
            end
            n_pending = '0;
        end
    end

    assign o_bundle = bundle;
    assign o_push   = accept && (bundle[0].valid || bundle[1].valid ||
                                 bundle[2].valid || bundle[3].valid);

    // Advance the classifier state on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.mode           <= M_NORMAL;
            r_st.quote_kind     <= 1'b0;
            r_st.held_slash     <= 1'b0;
            r_st.held_slash_spl <= '0;
            r_held_bs           <= 1'b0;
            r_held_bs_spl       <= '0;
            r_pending           <= '0;
            r_finished          <= 1'b0;
        end else if (accept) begin
            r_st          <= n_st;
            r_held_bs     <= n_held_bs;
            r_held_bs_spl <= n_held_bs_spl;
            r_pending     <= n_pending;
            r_finished    <= n_finished;
        end
    end

endmodule

`default_nettype wire

// ----- design/ccs_fifo.sv -----
`default_nettype none

module ccs_fifo import ccs_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_bundle i_data,
    input  wire logic    i_pop,
    output logic         o_full,
    output logic         o_nonempty,
    output t_bundle      o_data
);

    t_bundle             r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QPTR_W:0]     r_count;

    assign o_full     = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_data     = r_mem[r_rd];

    // Store the pushed bundle
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Move pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_nonempty)) else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- design/ccs_back.sv -----
`default_nettype none

module ccs_back import ccs_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_nonempty,
    input  wire t_bundle    i_bundle,
    output logic            o_pop,
    input  wire logic       i_stall,
    output logic            o_valid,
    output logic [7:0]      o_out_byte,
    output logic            o_has_byte,
    output logic            o_last,
    output logic [1:0]      o_error
);

    logic [SLOTS-1:0]  r_done, n_done;
    logic [SPL_W:0]    r_cnt, n_cnt;
    logic              r_valid;
    logic [7:0]        r_byte, n_byte;
    logic              r_has, n_has;
    logic              r_last, n_last;
    t_err              r_err, n_err;

    logic [SLOTS-1:0]  present, remain, cur_bit;
    logic [SLOT_W-1:0] cur_idx;
    t_slot             cur;
    logic              slot_end, advance, last_slot;

    // Pick the lowest slot still to be expanded
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            present[i] = i_bundle[i].valid;
        end
        remain  = present & ~r_done;
        cur_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (remain[i]) begin
                cur_idx = SLOT_W'(i);
            end
        end
        cur_bit   = SLOTS'(1) << cur_idx;
        cur       = i_bundle[cur_idx];
        last_slot = ((remain & ~cur_bit) == '0);
        slot_end  = cur.final_mark || (r_cnt == {cur.spl, 1'b0});
        advance   = i_nonempty && (!r_valid || !i_stall);
    end

    // Form the next result: splice pairs first, then the character
    always_comb begin
        n_byte = r_byte;
        n_has  = r_has;
        n_last = r_last;
        n_err  = r_err;
        n_cnt  = r_cnt;
        n_done = r_done;
        if (advance) begin
            if (cur.final_mark) begin
                n_byte = '0;
                n_has  = 1'b0;
                n_last = 1'b1;
                n_err  = cur.err;
            end else begin
                n_has  = 1'b1;
                n_last = 1'b0;
                n_err  = ERR_NONE;
                if (slot_end) begin
                    n_byte = cur.ch;
                end else begin
                    n_byte = r_cnt[0] ? CH_NL : CH_BSLASH;
                end
            end
            if (slot_end) begin
                n_cnt  = '0;
                n_done = last_slot ? '0 : (r_done | cur_bit);
            end else begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    assign o_pop = advance && slot_end && last_slot;

    // Hold the output until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
            r_done  <= '0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
            if (advance) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_has  <= n_has;
        r_last <= n_last;
        r_err  <= n_err;
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_byte;
    assign o_has_byte = r_has;
    assign o_last     = r_last;
    assign o_error    = r_err;

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_has) |-> r_last) else $error("result without byte is not final");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (SPL_W+1)'(2 * MAX_SPLICES)) else $error("splice counter out of range");

endmodule

`default_nettype wire

// ----- design/c_comment_stripper.sv -----
// C comment stripper. Takes C source one byte per request (i_valid/o_stall)
// and returns the source with comments removed, one result per request on
// the output side (o_valid/i_stall). Backslash-newline splices are removed and
// put back in front of the next kept character; // comments vanish up to the
// newline, /* */ comments become one space, quoted literals pass unchanged.
// i_end_of_input closes the stream with one result that has o_last set and
// o_error giving 0 (clean), 1 (open comment) or 2 (open literal); requests
// after that are taken and ignored until reset. The classifier accepts one
// byte every cycle while the queue is not full; a kept character with n
// splices yields 2n+1 results, sent one per cycle by the expander while the
// output is not stalled, and a four-entry queue between the two holds back
// input only while that expansion trails the incoming bytes. A taken byte is
// written into the queue and its first result is then registered in the
// expander's output; a byte that keeps nothing produces no result.
`default_nettype none

module c_comment_stripper import ccs_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_end_of_input,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_has_byte,
    output logic            o_last,
    output logic [1:0]      o_error
);

    logic    push, pop, full, nonempty;
    t_bundle push_data, head_data;

    ccs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .i_full         (full),
        .o_stall        (o_stall),
        .o_push         (push),
        .o_bundle       (push_data)
    );

    ccs_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_data     (push_data),
        .i_pop      (pop),
        .o_full     (full),
        .o_nonempty (nonempty),
        .o_data     (head_data)
    );

    ccs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (nonempty),
        .i_bundle   (head_data),
        .o_pop      (pop),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_out_byte (o_out_byte),
        .o_has_byte (o_has_byte),
        .o_last     (o_last),
        .o_error    (o_error)
    );

endmodule

`default_nettype wire
